// ----- rtl/rpm_pkg.sv -----
// ----------------------------------------------------------------------------
// rpm_pkg
// Types and constants shared by the reed pulse meter with tamper detection.
// ----------------------------------------------------------------------------
`default_nettype none

package rpm_pkg;

    // configuration register indexes
    localparam int CfgIdxWidth = 3;

    typedef enum logic [CfgIdxWidth-1:0] {
        CFG_PULSE_THRESHOLD = 3'd0,
        CFG_RELEASE_TICKS   = 3'd1,
        CFG_DETECT_TICKS    = 3'd2,
        CFG_REOPEN_DELAY    = 3'd3,
        CFG_TAMPER_LIMIT    = 3'd4
    } cfg_idx_t;

    // configuration reset values
    localparam logic [7:0] PulseThresholdRst = 8'd2;
    localparam logic [3:0] ReleaseTicksRst   = 4'd3;
    localparam logic [3:0] DetectTicksRst    = 4'd4;
    localparam logic [7:0] ReopenDelayRst    = 8'd10;
    localparam logic [7:0] TamperLimitRst    = 8'd5;

    // counter ceilings
    localparam logic [7:0] LowTicksMax   = 8'hFF;
    localparam logic [3:0] HighTicksMax  = 4'hF;
    localparam logic [7:0] TamperCntMax  = 8'hFF;

    // tamper display codes
    localparam logic [1:0] DISP_NONE   = 2'd0;
    localparam logic [1:0] DISP_INTERF = 2'd1;
    localparam logic [1:0] DISP_REPEAT = 2'd2;

    typedef struct packed {
        logic [7:0] pulse_threshold;
        logic [3:0] release_ticks;
        logic [3:0] tamper_detect_ticks;
        logic [7:0] reopen_delay_ticks;
        logic [7:0] tamper_limit;
    } cfg_t;

    typedef struct packed {
        logic a_read_first;
        logic a_read_second;
        logic b_read_first;
        logic b_read_second;
    } in_t;

    typedef struct packed {
        logic [31:0] volume_tenths;
        logic        volume_step;
        logic        a_active;
        logic        b_active;
        logic        valve_close;
        logic        valve_open;
        logic        tamper_active;
        logic [1:0]  tamper_display;
        logic [7:0]  tamper_count;
    } out_t;

    typedef struct packed {
        logic        a_latched;
        logic [7:0]  a_low_ticks;
        logic [3:0]  a_high_ticks;
        logic [7:0]  a_pulse_len;
        logic [3:0]  a_gap_len;
        logic        b_latched;
        logic [7:0]  b_low_ticks;
        logic [7:0]  b_pulse_len;
        logic [31:0] volume_total;
        logic [3:0]  both_low_run;
        logic        interference_latched;
        logic [7:0]  interference_count;
        logic        reopen_pending;
        logic [7:0]  reopen_timer;
        logic [1:0]  display_code;
        logic        tamper_flag;
    } state_t;

endpackage

`default_nettype wire

// ----- rtl/reed_pulse_meter_with_tamper.sv -----
// A tick request's result is registered and shows in the cycle after it is accepted.
// Throughput: one tick per cycle while m_ready holds; the meter state register feeds the
// tick logic straight back, and the result register frees as it is taken.
// Reset (aresetn, synchronous, active low): all meter state and counts clear,
// configuration returns to its default values, no result is pending.
// ----------------------------------------------------------------------------
// reed_pulse_meter_with_tamper
// Reed switch pulse meter with magnetic interference detection and valve
// control; one tick request in, one result out.
// ----------------------------------------------------------------------------
`default_nettype none

module reed_pulse_meter_with_tamper
    import rpm_pkg::*;
(
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    // tick requests
    input  wire logic                   s_valid,
    output logic                        s_ready,
    input  wire in_t                    s_data,
    // results
    output logic                        m_valid,
    input  wire logic                   m_ready,
    output out_t                        m_data,
    // configuration writes
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CfgIdxWidth-1:0] cfg_index,
    input  wire logic [7:0]             cfg_data
);

    cfg_t   cfg;
    state_t state_reg;
    state_t state_next;
    out_t   res;
    out_t   m_data_reg;
    logic   m_valid_reg;
    logic   accept;

    rpm_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    rpm_step u_step (
        .cur  (state_reg),
        .tick (s_data),
        .cfg  (cfg),
        .nxt  (state_next),
        .res  (res)
    );

    // take a request whenever the result register is empty or draining
    assign s_ready = ~m_valid_reg | m_ready;
    assign accept  = s_valid & s_ready;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // meter state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= '0;
        end else if (accept) begin
            state_reg <= state_next;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (accept) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            m_data_reg <= res;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/rpm_cfg.sv -----
// ----------------------------------------------------------------------------
// rpm_cfg
// Configuration register bank, written through its own request channel.
// ----------------------------------------------------------------------------
`default_nettype none

module rpm_cfg
    import rpm_pkg::*;
(
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CfgIdxWidth-1:0] cfg_index,
    input  wire logic [7:0]             cfg_data,
    output cfg_t                        cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // writes are always taken
    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    // register decode, unknown indexes ignored
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (cfg_idx_t'(cfg_index))
                CFG_PULSE_THRESHOLD: cfg_next.pulse_threshold     = cfg_data;
                CFG_RELEASE_TICKS:   cfg_next.release_ticks       = cfg_data[3:0];
                CFG_DETECT_TICKS:    cfg_next.tamper_detect_ticks = cfg_data[3:0];
                CFG_REOPEN_DELAY:    cfg_next.reopen_delay_ticks  = cfg_data;
                CFG_TAMPER_LIMIT:    cfg_next.tamper_limit        = cfg_data;
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.pulse_threshold     <= PulseThresholdRst;
            cfg_reg.release_ticks       <= ReleaseTicksRst;
            cfg_reg.tamper_detect_ticks <= DetectTicksRst;
            cfg_reg.reopen_delay_ticks  <= ReopenDelayRst;
            cfg_reg.tamper_limit        <= TamperLimitRst;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/rpm_step.sv -----
// ----------------------------------------------------------------------------
// rpm_step
// Next-state and result logic for one tick: metering, volume, interference.
// ----------------------------------------------------------------------------
`default_nettype none

module rpm_step
    import rpm_pkg::*;
(
    input  state_t cur,
    input  in_t    tick,
    input  cfg_t   cfg,
    output state_t nxt,
    output out_t   res
);

    logic   a_low;
    logic   a_high;
    logic   b_low;
    logic   b_high;
    logic   step;
    logic   close_cmd;
    logic   open_cmd;
    state_t st;

    // qualified levels from the two debounce reads
    assign a_low  = ~tick.a_read_first & ~tick.a_read_second;
    assign a_high =  tick.a_read_first &  tick.a_read_second;
    assign b_low  = ~tick.b_read_first & ~tick.b_read_second;
    assign b_high =  tick.b_read_first &  tick.b_read_second;

    always_comb begin
        st        = cur;
        step      = 1'b0;
        close_cmd = 1'b0;
        open_cmd  = 1'b0;

        // channel a metering
        if (!st.a_latched && a_low) begin
            if (st.a_low_ticks != LowTicksMax) begin
                st.a_low_ticks = st.a_low_ticks + 8'd1;
            end
            if (st.a_low_ticks > cfg.pulse_threshold) begin
                st.a_latched = 1'b1;
            end
        end
        if (st.a_latched && a_high) begin
            if (st.a_high_ticks != HighTicksMax) begin
                st.a_high_ticks = st.a_high_ticks + 4'd1;
            end
            if (st.a_high_ticks > cfg.release_ticks) begin
                st.a_pulse_len  = st.a_low_ticks;
                st.a_low_ticks  = 8'd0;
                st.a_gap_len    = st.a_high_ticks;
                st.a_high_ticks = 4'd0;
                st.a_latched    = 1'b0;
            end
        end

        // channel b metering, released on first high
        if (!st.b_latched && b_low) begin
            if (st.b_low_ticks != LowTicksMax) begin
                st.b_low_ticks = st.b_low_ticks + 8'd1;
            end
            if (st.b_low_ticks > cfg.pulse_threshold) begin
                st.b_latched = 1'b1;
            end
        end
        if (st.b_latched && b_high) begin
            st.b_pulse_len = st.b_low_ticks;
            st.b_low_ticks = 8'd0;
            st.b_latched   = 1'b0;
        end

        // volume check on the stored pulse, gap, pulse sequence
        if (st.a_pulse_len >= cfg.pulse_threshold &&
            st.a_gap_len >= cfg.release_ticks &&
            st.b_pulse_len >= cfg.pulse_threshold) begin
            st.a_pulse_len  = 8'd0;
            st.a_gap_len    = 4'd0;
            st.b_pulse_len  = 8'd0;
            st.volume_total = st.volume_total + 32'd1;
            step            = 1'b1;
        end

        // interference detection on the first reads
        if (!tick.a_read_first && !tick.b_read_first && !st.interference_latched) begin
            st.both_low_run = st.both_low_run + 4'd1;
            if (st.both_low_run == cfg.tamper_detect_ticks) begin
                st.display_code         = DISP_INTERF;
                st.interference_latched = 1'b1;
                st.both_low_run         = 4'd0;
                close_cmd               = 1'b1;
                st.tamper_flag          = 1'b1;
                if (st.interference_count != TamperCntMax) begin
                    st.interference_count = st.interference_count + 8'd1;
                end
                if (st.interference_count >= cfg.tamper_limit) begin
                    st.display_code = DISP_REPEAT;
                end
            end
        end else begin
            st.both_low_run = 4'd0;
        end

        // interference release, blocked once the limit is reached
        if (st.interference_latched && (tick.a_read_first || tick.b_read_first) &&
            st.interference_count < cfg.tamper_limit) begin
            st.a_latched            = 1'b0;
            st.both_low_run         = 4'd0;
            st.reopen_pending       = 1'b1;
            st.interference_latched = 1'b0;
        end

        // reopen delay
        if (st.reopen_pending) begin
            st.reopen_timer = st.reopen_timer + 8'd1;
            if (st.reopen_timer == cfg.reopen_delay_ticks) begin
                st.reopen_timer   = 8'd0;
                st.reopen_pending = 1'b0;
                open_cmd          = 1'b1;
                if (st.display_code == DISP_INTERF) begin
                    st.display_code = DISP_NONE;
                end
                if (st.interference_count < cfg.tamper_limit) begin
                    st.tamper_flag = 1'b0;
                end
            end
        end
    end

    assign nxt = st;

    // result fields
    always_comb begin
        res.volume_tenths  = st.volume_total;
        res.volume_step    = step;
        res.a_active       = st.a_latched;
        res.b_active       = st.b_latched;
        res.valve_close    = close_cmd;
        res.valve_open     = open_cmd;
        res.tamper_active  = st.tamper_flag;
        res.tamper_display = st.display_code;
        res.tamper_count   = st.interference_count;
    end

endmodule

`default_nettype wire
